@@ rtl/mkd_pkg.sv @@
// Shared types, constants and the letter table of the Morse key decoder.
package mkd_pkg;

	localparam int MESSAGE_DEPTH  = 32;
	localparam int LETTER_SYMBOLS = 4;
	localparam int ALPHA_COUNT    = 26;

	localparam int IDX_W = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
	localparam int LEN_W = $clog2(MESSAGE_DEPTH + 1);
	localparam int CNT_W = $clog2(LETTER_SYMBOLS + 1);

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [LEN_W-1:0]          len_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [LETTER_SYMBOLS-1:0] sym_bits_t;
	typedef logic [6:0]                char_t;
	typedef logic [15:0]               ms_t;
	typedef logic [1:0]                kind_t;
	typedef logic [2:0]                reg_idx_t;
	typedef logic [4:0]                pos_t;

	// event kinds
	localparam kind_t KIND_KEY  = 2'd0;
	localparam kind_t KIND_SEND = 2'd1;
	localparam kind_t KIND_SEP  = 2'd2;

	// result kinds
	localparam kind_t RK_APPENDED = 2'd0;
	localparam kind_t RK_REFUSED  = 2'd1;
	localparam kind_t RK_SENT     = 2'd2;
	localparam kind_t RK_EMPTY    = 2'd3;

	// register indexes
	localparam reg_idx_t REG_DOT_TIME   = 3'd0;
	localparam reg_idx_t REG_DASH_TIME  = 3'd1;
	localparam reg_idx_t REG_TOLERANCE  = 3'd2;
	localparam reg_idx_t REG_LETTER_GAP = 3'd3;
	localparam reg_idx_t REG_WORD_GAP   = 3'd4;

	localparam ms_t RST_DOT_TIME   = 16'd1000;
	localparam ms_t RST_DASH_TIME  = 16'd3000;
	localparam ms_t RST_TOLERANCE  = 16'd500;
	localparam ms_t RST_LETTER_GAP = 16'd3000;
	localparam ms_t RST_WORD_GAP   = 16'd7000;

	localparam char_t CHAR_NONE  = 7'd0;
	localparam char_t CHAR_SPACE = 7'd32;
	localparam int    LETTER_A   = 65;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEND_RD,
		ST_SEND_OUT
	} state_t;

	typedef struct packed {
		logic latch;
		logic key;
		logic sep;
		logic empty_send;
		logic send_start;
		logic send_read;
		logic send_emit;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  len_zero;
		logic  send_last;
		logic  out_free;
	} status_t;

	typedef struct packed {
		logic [2:0] len;
		logic [3:0] bits;
	} pattern_t;

	// international alphabet, symbol i in bit i, 1 = dash
	localparam pattern_t MORSE_ROM [ALPHA_COUNT] = '{
		'{3'd2, 4'd2},  '{3'd4, 4'd1},  '{3'd4, 4'd5},  '{3'd3, 4'd1},  '{3'd1, 4'd0},
		'{3'd4, 4'd4},  '{3'd3, 4'd3},  '{3'd4, 4'd0},  '{3'd2, 4'd0},  '{3'd4, 4'd14},
		'{3'd3, 4'd5},  '{3'd4, 4'd2},  '{3'd2, 4'd3},  '{3'd2, 4'd1},  '{3'd3, 4'd7},
		'{3'd4, 4'd6},  '{3'd4, 4'd11}, '{3'd3, 4'd2},  '{3'd3, 4'd0},  '{3'd1, 4'd1},
		'{3'd3, 4'd4},  '{3'd4, 4'd8},  '{3'd3, 4'd6},  '{3'd4, 4'd9},  '{3'd4, 4'd13},
		'{3'd4, 4'd3}
	};

	// letter for a symbol pattern, CHAR_NONE when empty or unknown
	function automatic char_t lookup_letter(cnt_t count, sym_bits_t bits);
		logic [4:0] m5;
		logic [3:0] pat;
		char_t      ch;
		m5  = (5'd1 << count) - 5'd1;
		pat = bits[3:0] & m5[3:0];
		ch  = CHAR_NONE;
		if (count != '0 && count <= cnt_t'(4)) begin
			for (int i = 0; i < ALPHA_COUNT; i++) begin
				if (cnt_t'(MORSE_ROM[i].len) == count && MORSE_ROM[i].bits == pat) begin
					ch = ch | char_t'(LETTER_A + i);
				end
			end
		end
		return ch;
	endfunction

	// message index masked to the position field
	function automatic pos_t pos_of(idx_t i);
		logic [IDX_W+4:0] e;
		e = {5'd0, i};
		return e[4:0];
	endfunction

endpackage

@@ rtl/mkd_ctrl.sv @@
// Controller state machine of the Morse key decoder.
module mkd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mkd_pkg::status_t status,
	output mkd_pkg::cmd_t    cmd,
	output mkd_pkg::state_t  state
);

	mkd_pkg::state_t state_q;
	mkd_pkg::state_t state_d;

	assign state    = state_q;
	assign in_stall = !(state_q == mkd_pkg::ST_IDLE && status.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mkd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mkd_pkg::ST_IDLE: begin
				if (in_valid && !in_stall) state_d = mkd_pkg::ST_EXEC;
			end
			mkd_pkg::ST_EXEC: begin
				if (status.kind == mkd_pkg::KIND_SEND && !status.len_zero) begin
					state_d = mkd_pkg::ST_SEND_RD;
				end else begin
					state_d = mkd_pkg::ST_IDLE;
				end
			end
			mkd_pkg::ST_SEND_RD: begin
				state_d = mkd_pkg::ST_SEND_OUT;
			end
			mkd_pkg::ST_SEND_OUT: begin
				if (status.out_free) begin
					state_d = status.send_last ? mkd_pkg::ST_IDLE : mkd_pkg::ST_SEND_RD;
				end
			end
			default: state_d = mkd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			mkd_pkg::ST_IDLE: begin
				cmd.latch = in_valid && !in_stall;
			end
			mkd_pkg::ST_EXEC: begin
				case (status.kind)
					mkd_pkg::KIND_KEY:  cmd.key = 1'b1;
					mkd_pkg::KIND_SEP:  cmd.sep = 1'b1;
					mkd_pkg::KIND_SEND: begin
						cmd.empty_send = status.len_zero;
						cmd.send_start = !status.len_zero;
					end
					default: ;
				endcase
			end
			mkd_pkg::ST_SEND_RD: begin
				cmd.send_read = 1'b1;
			end
			mkd_pkg::ST_SEND_OUT: begin
				cmd.send_emit = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/mkd_datapath.sv @@
// Datapath of the Morse key decoder: registers, letter and message stores, result register.
module mkd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  mkd_pkg::reg_idx_t  cfg_index,
	input  mkd_pkg::ms_t       cfg_data,
	input  mkd_pkg::kind_t     kind,
	input  mkd_pkg::ms_t       press_time,
	input  logic               out_stall,
	output logic               out_valid,
	output mkd_pkg::kind_t     result_kind,
	output mkd_pkg::char_t     character,
	output mkd_pkg::pos_t      position,
	output logic               last,
	input  mkd_pkg::cmd_t      cmd,
	output mkd_pkg::status_t   status
);

	mkd_pkg::ms_t dot_time_q, dash_time_q, tolerance_q, letter_gap_q, word_gap_q;

	mkd_pkg::kind_t    kind_q;
	mkd_pkg::ms_t      time_q;
	mkd_pkg::sym_bits_t bits_q;
	mkd_pkg::cnt_t     count_q;
	mkd_pkg::len_t     len_q;
	mkd_pkg::idx_t     rd_idx_q;
	mkd_pkg::char_t    rd_data_q;
	mkd_pkg::char_t    mem_q [mkd_pkg::MESSAGE_DEPTH];

	logic            out_valid_q;
	mkd_pkg::kind_t  out_kind_q;
	mkd_pkg::char_t  out_char_q;
	mkd_pkg::pos_t   out_pos_q;
	logic            out_last_q;

	mkd_pkg::ms_t   dot_diff, dash_diff;
	logic           dot_near, dash_near, sym_take;
	logic           gap_ok, room;
	mkd_pkg::char_t sep_char;
	logic           sep_write;
	logic           send_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_time_q   <= mkd_pkg::RST_DOT_TIME;
			dash_time_q  <= mkd_pkg::RST_DASH_TIME;
			tolerance_q  <= mkd_pkg::RST_TOLERANCE;
			letter_gap_q <= mkd_pkg::RST_LETTER_GAP;
			word_gap_q   <= mkd_pkg::RST_WORD_GAP;
		end else if (cfg_valid) begin
			case (cfg_index)
				mkd_pkg::REG_DOT_TIME:   dot_time_q   <= cfg_data;
				mkd_pkg::REG_DASH_TIME:  dash_time_q  <= cfg_data;
				mkd_pkg::REG_TOLERANCE:  tolerance_q  <= cfg_data;
				mkd_pkg::REG_LETTER_GAP: letter_gap_q <= cfg_data;
				mkd_pkg::REG_WORD_GAP:   word_gap_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			time_q <= press_time;
		end
	end

	// classify the press: dot wins over dash
	assign dot_diff  = (time_q > dot_time_q) ? time_q - dot_time_q : dot_time_q - time_q;
	assign dash_diff = (time_q > dash_time_q) ? time_q - dash_time_q : dash_time_q - time_q;
	assign dot_near  = dot_diff < tolerance_q;
	assign dash_near = dash_diff < tolerance_q;
	assign sym_take  = (dot_near || dash_near) &&
		(count_q < mkd_pkg::cnt_t'(mkd_pkg::LETTER_SYMBOLS));

	assign gap_ok    = time_q > letter_gap_q;
	assign sep_char  = (time_q > word_gap_q) ? mkd_pkg::CHAR_SPACE :
		mkd_pkg::lookup_letter(count_q, bits_q);
	assign room      = len_q < mkd_pkg::len_t'(mkd_pkg::MESSAGE_DEPTH);
	assign sep_write = cmd.sep && gap_ok && sep_char != mkd_pkg::CHAR_NONE && room;
	assign send_last = mkd_pkg::len_t'(rd_idx_q) + mkd_pkg::len_t'(1) == len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			count_q <= '0;
		end else if (cmd.key && sym_take) begin
			if (!dot_near) bits_q <= bits_q | (mkd_pkg::sym_bits_t'(1) << count_q);
			count_q <= count_q + mkd_pkg::cnt_t'(1);
		end else if (cmd.sep && gap_ok) begin
			bits_q  <= '0;
			count_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (sep_write) len_q <= len_q + mkd_pkg::len_t'(1);
			if (cmd.send_start) rd_idx_q <= '0;
			if (cmd.send_emit) begin
				rd_idx_q <= rd_idx_q + mkd_pkg::idx_t'(1);
				if (send_last) len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sep_write) mem_q[len_q[mkd_pkg::IDX_W-1:0]] <= sep_char;
		if (cmd.send_read) rd_data_q <= mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.sep && gap_ok) || cmd.empty_send || cmd.send_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sep && gap_ok) begin
			out_last_q <= 1'b1;
			if (sep_char == mkd_pkg::CHAR_NONE) begin
				out_kind_q <= mkd_pkg::RK_REFUSED;
				out_char_q <= mkd_pkg::CHAR_NONE;
				out_pos_q  <= '0;
			end else if (room) begin
				out_kind_q <= mkd_pkg::RK_APPENDED;
				out_char_q <= sep_char;
				out_pos_q  <= mkd_pkg::pos_of(len_q[mkd_pkg::IDX_W-1:0]);
			end else begin
				out_kind_q <= mkd_pkg::RK_REFUSED;
				out_char_q <= sep_char;
				out_pos_q  <= '0;
			end
		end else if (cmd.empty_send) begin
			out_kind_q <= mkd_pkg::RK_EMPTY;
			out_char_q <= mkd_pkg::CHAR_NONE;
			out_pos_q  <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.send_emit) begin
			out_kind_q <= mkd_pkg::RK_SENT;
			out_char_q <= rd_data_q;
			out_pos_q  <= mkd_pkg::pos_of(rd_idx_q);
			out_last_q <= send_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign character   = out_char_q;
	assign position    = out_pos_q;
	assign last        = out_last_q;

	assign status.kind      = kind_q;
	assign status.len_zero  = len_q == '0;
	assign status.send_last = send_last;
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

@@ rtl/morse_key_decoder_core.sv @@
// Top level of the Morse key decoder: controller, datapath and checks.
//
// Input channel (in_valid/in_stall) carries timed button events: kind and
// press_time. Results leave on out_valid/out_stall as result_kind,
// character, position and last. Registers are written on the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is always high and
// writes belong in idle periods only.
// An event is taken in one cycle and executed in the next. A separator
// that decodes a letter, or an empty send, loads its result into the
// result register when it is executed. A send reads the message store
// one character at a time (read, then load into the result register).
// A new event is taken only while the controller is idle and the result
// register is empty or being taken. When the receiver stalls, the result
// register holds and the send sequence waits with it.
// Reset restores the register defaults and clears the letter store and
// message length; message store contents are not cleared.
module morse_key_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mkd_pkg::kind_t    kind,
	input  mkd_pkg::ms_t      press_time,
	output logic              out_valid,
	input  logic              out_stall,
	output mkd_pkg::kind_t    result_kind,
	output mkd_pkg::char_t    character,
	output mkd_pkg::pos_t     position,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  mkd_pkg::reg_idx_t cfg_index,
	input  mkd_pkg::ms_t      cfg_data
);

	mkd_pkg::cmd_t    cmd;
	mkd_pkg::status_t status;
	mkd_pkg::state_t  state;

	assign cfg_ready = 1'b1;

	mkd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	mkd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.press_time  (press_time),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.character   (character),
		.position    (position),
		.last        (last),
		.cmd         (cmd),
		.status      (status)
	);

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state == mkd_pkg::ST_EXEC)
		else $error("accepted request not executed next cycle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send_emit |-> (!out_valid || !out_stall))
		else $error("send overwrote a pending result");

	a_send_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state == mkd_pkg::ST_SEND_RD || state == mkd_pkg::ST_SEND_OUT) |-> in_stall)
		else $error("request taken during send");

	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.send_emit && status.send_last) |=> status.len_zero && out_valid && last)
		else $error("message not cleared after final character");

endmodule

@@ tb/sv/tb_morse_key_decoder_core.sv @@
// Self-checking testbench for the Morse key decoder core.
`timescale 1ns / 1ps

module tb_morse_key_decoder_core;

	localparam mkd_pkg::kind_t KIND_UNUSED   = 2'd3;
	localparam int             SETTLE_CYCLES = 8;
	localparam int             CYCLE_LIMIT   = 1_000_000;
	localparam int             LONG_HOLD     = 300;

	typedef struct packed {
		mkd_pkg::kind_t rk;
		mkd_pkg::char_t ch;
		mkd_pkg::pos_t  pos;
		logic           last;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	mkd_pkg::kind_t    kind;
	mkd_pkg::ms_t      press_time;
	logic              out_valid;
	logic              out_stall;
	mkd_pkg::kind_t    result_kind;
	mkd_pkg::char_t    character;
	mkd_pkg::pos_t     position;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	mkd_pkg::reg_idx_t cfg_index;
	mkd_pkg::ms_t      cfg_data;

	// mirror of the decoder state
	mkd_pkg::ms_t       cfg_dot_ms, cfg_dash_ms, cfg_tol_ms, cfg_letter_gap_ms, cfg_word_gap_ms;
	mkd_pkg::sym_bits_t letter_bits;
	mkd_pkg::cnt_t      letter_len;
	mkd_pkg::char_t     msg_chars [mkd_pkg::MESSAGE_DEPTH];
	mkd_pkg::len_t      msg_len;

	result_t message_results [$];

	int events_sent = 0;
	int mismatches  = 0;
	int cycle_count = 0;
	int long_hold   = 0;
	bit idle_en     = 1'b1;

	morse_key_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.press_time  (press_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.character   (character),
		.position    (position),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// international alphabet, dot and dash written out
	function automatic string morse_code(int i);
		case (i)
			0: return ".-";
			1: return "-...";
			2: return "-.-.";
			3: return "-..";
			4: return ".";
			5: return "..-.";
			6: return "--.";
			7: return "....";
			8: return "..";
			9: return ".---";
			10: return "-.-";
			11: return ".-..";
			12: return "--";
			13: return "-.";
			14: return "---";
			15: return ".--.";
			16: return "--.-";
			17: return ".-.";
			18: return "...";
			19: return "-";
			20: return "..-";
			21: return "...-";
			22: return ".--";
			23: return "-..-";
			24: return "-.--";
			25: return "--..";
			default: return "";
		endcase
	endfunction

	function automatic bit within_tol(mkd_pkg::ms_t t, mkd_pkg::ms_t nominal);
		int d;
		d = (t > nominal) ? int'(t) - int'(nominal) : int'(nominal) - int'(t);
		return d < int'(cfg_tol_ms);
	endfunction

	function automatic mkd_pkg::char_t letter_char();
		string code;
		bit    same;
		for (int i = 0; i < mkd_pkg::ALPHA_COUNT; i++) begin
			code = morse_code(i);
			if (code.len() == int'(letter_len)) begin
				same = 1'b1;
				for (int j = 0; j < code.len(); j++) begin
					if ((code[j] == "-") != letter_bits[j]) same = 1'b0;
				end
				if (same) return mkd_pkg::char_t'(mkd_pkg::LETTER_A + i);
			end
		end
		return mkd_pkg::CHAR_NONE;
	endfunction

	// advance the mirror by one accepted request, queue the results it causes
	function automatic void apply_key_event(mkd_pkg::kind_t k, mkd_pkg::ms_t t);
		int             sym;
		mkd_pkg::char_t ch;
		if (k == mkd_pkg::KIND_KEY) begin
			sym = -1;
			if (within_tol(t, cfg_dot_ms)) sym = 0;
			else if (within_tol(t, cfg_dash_ms)) sym = 1;
			if (sym >= 0 && letter_len < mkd_pkg::LETTER_SYMBOLS) begin
				letter_bits[letter_len] = (sym == 1);
				letter_len++;
			end
		end else if (k == mkd_pkg::KIND_SEP) begin
			if (t > cfg_letter_gap_ms) begin
				ch          = (t > cfg_word_gap_ms) ? mkd_pkg::CHAR_SPACE : letter_char();
				letter_bits = '0;
				letter_len  = '0;
				if (ch == mkd_pkg::CHAR_NONE) begin
					message_results.push_back('{mkd_pkg::RK_REFUSED, mkd_pkg::CHAR_NONE,
						mkd_pkg::pos_t'(0), 1'b1});
				end else if (msg_len < mkd_pkg::MESSAGE_DEPTH) begin
					msg_chars[msg_len] = ch;
					message_results.push_back('{mkd_pkg::RK_APPENDED, ch,
						mkd_pkg::pos_t'(msg_len), 1'b1});
					msg_len++;
				end else begin
					message_results.push_back('{mkd_pkg::RK_REFUSED, ch,
						mkd_pkg::pos_t'(0), 1'b1});
				end
			end
		end else if (k == mkd_pkg::KIND_SEND) begin
			if (msg_len == 0) begin
				message_results.push_back('{mkd_pkg::RK_EMPTY, mkd_pkg::CHAR_NONE,
					mkd_pkg::pos_t'(0), 1'b1});
			end else begin
				for (int i = 0; i < int'(msg_len); i++) begin
					message_results.push_back('{mkd_pkg::RK_SENT, msg_chars[i],
						mkd_pkg::pos_t'(i), logic'(i + 1 == int'(msg_len))});
				end
				msg_len = '0;
			end
		end
	endfunction

	function automatic void log_mismatch(string what);
		mismatches++;
		if (mismatches <= 10) $display("%0t: %s", $time, what);
	endfunction

	always @(negedge clk) begin : check_results
		result_t got, want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = '{result_kind, character, position, last};
			if (message_results.size() == 0) begin
				log_mismatch($sformatf("unexpected result kind %0d char %0d pos %0d last %0b",
					got.rk, got.ch, got.pos, got.last));
			end else begin
				want = message_results.pop_front();
				if (got !== want) begin
					log_mismatch($sformatf({"result mismatch: expected kind %0d char %0d pos %0d ",
						"last %0b, got kind %0d char %0d pos %0d last %0b"},
						want.rk, want.ch, want.pos, want.last,
						got.rk, got.ch, got.pos, got.last));
				end
			end
		end
	end

	initial begin : receiver_pacing
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && long_hold > 0) begin
				stall_left = long_hold;
				long_hold  = 0;
			end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one request and hold it until taken; valid stays high for the next one
	task automatic send_event(mkd_pkg::kind_t k, mkd_pkg::ms_t t);
		logic held;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		press_time <= t;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held !== 1'b0);
		apply_key_event(k, t);
		events_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (message_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timing(mkd_pkg::ms_t dot, mkd_pkg::ms_t dash, mkd_pkg::ms_t tol,
		mkd_pkg::ms_t lgap, mkd_pkg::ms_t wgap);
		mkd_pkg::reg_idx_t idx [5];
		mkd_pkg::ms_t      vals [5];
		logic              rdy;
		idx  = '{mkd_pkg::REG_DOT_TIME, mkd_pkg::REG_DASH_TIME, mkd_pkg::REG_TOLERANCE,
			mkd_pkg::REG_LETTER_GAP, mkd_pkg::REG_WORD_GAP};
		vals = '{dot, dash, tol, lgap, wgap};
		wait_drained();
		for (int r = 0; r < 5; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[r];
			cfg_data  <= vals[r];
			do begin
				@(negedge clk);
				rdy = cfg_ready;
				@(posedge clk);
			end while (rdy !== 1'b1);
			case (idx[r])
				mkd_pkg::REG_DOT_TIME: cfg_dot_ms = vals[r];
				mkd_pkg::REG_DASH_TIME: cfg_dash_ms = vals[r];
				mkd_pkg::REG_TOLERANCE: cfg_tol_ms = vals[r];
				mkd_pkg::REG_LETTER_GAP: cfg_letter_gap_ms = vals[r];
				mkd_pkg::REG_WORD_GAP: cfg_word_gap_ms = vals[r];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// a duration strictly inside the tolerance window of nominal, or nominal itself when the tolerance is zero
	function automatic mkd_pkg::ms_t near_time(mkd_pkg::ms_t nominal);
		int lo, hi;
		if (cfg_tol_ms == 0) return nominal;
		lo = int'(nominal) - int'(cfg_tol_ms) + 1;
		hi = int'(nominal) + int'(cfg_tol_ms) - 1;
		if (lo < 0) lo = 0;
		if (hi > 65535) hi = 65535;
		return mkd_pkg::ms_t'($urandom_range(hi, lo));
	endfunction

	function automatic mkd_pkg::ms_t letter_sep_time();
		int hi;
		if (cfg_letter_gap_ms == 16'hFFFF) return 16'hFFFF;
		hi = (cfg_word_gap_ms > cfg_letter_gap_ms) ? int'(cfg_word_gap_ms) : 65535;
		return mkd_pkg::ms_t'($urandom_range(hi, int'(cfg_letter_gap_ms) + 1));
	endfunction

	function automatic mkd_pkg::ms_t word_sep_time();
		int lo;
		lo = (cfg_word_gap_ms > cfg_letter_gap_ms) ? int'(cfg_word_gap_ms)
			: int'(cfg_letter_gap_ms);
		if (lo == 65535) return 16'hFFFF;
		return mkd_pkg::ms_t'($urandom_range(65535, lo + 1));
	endfunction

	// key one letter, optionally with a stray press mixed in, then close it
	task automatic send_letter(int idx, bit noisy);
		string code;
		int    junk_at;
		code    = morse_code(idx);
		junk_at = noisy ? $urandom_range(0, code.len()) : -1;
		for (int j = 0; j <= code.len(); j++) begin
			if (j == junk_at) send_event(mkd_pkg::KIND_KEY, mkd_pkg::ms_t'($urandom));
			if (j < code.len()) begin
				send_event(mkd_pkg::KIND_KEY,
					near_time((code[j] == "-") ? cfg_dash_ms : cfg_dot_ms));
			end
		end
		send_event(mkd_pkg::KIND_SEP, letter_sep_time());
	endtask

	task automatic random_keying(int count);
		int stop;
		int pick;
		stop = events_sent + count;
		while (events_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_letter($urandom_range(0, mkd_pkg::ALPHA_COUNT - 1),
					$urandom_range(0, 9) == 0);
			end else if (pick < 75) begin
				send_event(mkd_pkg::KIND_SEP, word_sep_time());
			end else if (pick < 80) begin
				send_event(mkd_pkg::KIND_SEND, mkd_pkg::ms_t'($urandom));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6)) begin
					send_event(mkd_pkg::KIND_KEY, mkd_pkg::ms_t'($urandom));
				end
				send_event(mkd_pkg::KIND_SEP, mkd_pkg::ms_t'($urandom));
			end else begin
				send_event(mkd_pkg::kind_t'($urandom_range(0, 3)), mkd_pkg::ms_t'($urandom));
			end
		end
	endtask

	// reset timing: window edges, full letter store, unknown and empty letters
	task automatic test_directed_cases();
		send_event(mkd_pkg::KIND_SEND, 16'hFFFF);
		send_event(mkd_pkg::KIND_KEY, 16'd1000);
		send_event(mkd_pkg::KIND_SEP, 16'd3001);
		send_event(mkd_pkg::KIND_KEY, 16'd501);
		send_event(mkd_pkg::KIND_KEY, 16'd2501);
		send_event(mkd_pkg::KIND_KEY, 16'd3499);
		send_event(mkd_pkg::KIND_KEY, 16'd3000);
		send_event(mkd_pkg::KIND_SEP, 16'd7000);
		repeat (5) send_event(mkd_pkg::KIND_KEY, 16'd1499);
		send_event(mkd_pkg::KIND_SEP, 16'd5000);
		send_event(mkd_pkg::KIND_KEY, 16'd0);
		send_event(mkd_pkg::KIND_KEY, 16'hFFFF);
		repeat (4) send_event(mkd_pkg::KIND_KEY, 16'd3000);
		send_event(mkd_pkg::KIND_SEP, 16'd4000);
		send_event(mkd_pkg::KIND_SEP, 16'd4000);
		send_event(mkd_pkg::KIND_SEP, 16'd3000);
		send_event(KIND_UNUSED, 16'hFFFF);
		send_event(mkd_pkg::KIND_SEP, 16'hFFFF);
		send_event(mkd_pkg::KIND_SEND, 16'd0);
	endtask

	task automatic test_message_full();
		repeat (mkd_pkg::MESSAGE_DEPTH) send_event(mkd_pkg::KIND_SEP, word_sep_time());
		send_letter(4, 1'b0);
		send_event(mkd_pkg::KIND_SEND, 16'd1);
	endtask

	task automatic test_timing_extremes();
		set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_keying(25);
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_keying(25);
		// overlapping windows, every press is near the dot or the dash time
		set_timing(16'hFFFF, 16'd0, 16'd40000, 16'd0, 16'hFFFF);
		random_keying(25);
	endtask

	task automatic test_random_keying();
		int dot, lgap;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) begin
				set_timing(mkd_pkg::RST_DOT_TIME, mkd_pkg::RST_DASH_TIME,
					mkd_pkg::RST_TOLERANCE, mkd_pkg::RST_LETTER_GAP, mkd_pkg::RST_WORD_GAP);
			end else begin
				dot  = $urandom_range(50, 3000);
				lgap = $urandom_range(0, 8000);
				set_timing(mkd_pkg::ms_t'(dot), mkd_pkg::ms_t'(dot * 3),
					mkd_pkg::ms_t'($urandom_range(0, dot)), mkd_pkg::ms_t'(lgap),
					mkd_pkg::ms_t'(lgap + $urandom_range(0, 8000)));
			end
			random_keying(45);
		end
	endtask

	// hold the output long enough for the block to stall its input
	task automatic test_output_backpressure();
		set_timing(mkd_pkg::RST_DOT_TIME, mkd_pkg::RST_DASH_TIME, mkd_pkg::RST_TOLERANCE,
			mkd_pkg::RST_LETTER_GAP, mkd_pkg::RST_WORD_GAP);
		long_hold = LONG_HOLD;
		repeat (6) send_letter($urandom_range(0, mkd_pkg::ALPHA_COUNT - 1), 1'b0);
		send_event(mkd_pkg::KIND_SEND, 16'd0);
		wait_drained();
		repeat (3) send_letter($urandom_range(0, mkd_pkg::ALPHA_COUNT - 1), 1'b0);
		send_event(mkd_pkg::KIND_SEND, 16'd0);
	endtask

	task automatic test_unpaced_tail();
		idle_en = 1'b0;
		random_keying(40);
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		kind       <= mkd_pkg::KIND_KEY;
		press_time <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= mkd_pkg::REG_DOT_TIME;
		cfg_data   <= '0;
		cfg_dot_ms        = mkd_pkg::RST_DOT_TIME;
		cfg_dash_ms       = mkd_pkg::RST_DASH_TIME;
		cfg_tol_ms        = mkd_pkg::RST_TOLERANCE;
		cfg_letter_gap_ms = mkd_pkg::RST_LETTER_GAP;
		cfg_word_gap_ms   = mkd_pkg::RST_WORD_GAP;
		letter_bits       = '0;
		letter_len        = '0;
		msg_len           = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_message_full();
		test_timing_extremes();
		test_random_keying();
		test_output_backpressure();
		test_unpaced_tail();
		wait_drained();

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mkd_pkg.sv
rtl/mkd_ctrl.sv
rtl/mkd_datapath.sv
rtl/morse_key_decoder_core.sv
tb/sv/tb_morse_key_decoder_core.sv
